// File: hdl/misp_pkg.sv
// Shared types, character codes and line-parse functions for the MI record stream parser.
// Used by misp_front, misp_queue, misp_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package misp_pkg;

  localparam int TOKEN_W = 32;      // token accumulator width, range 8..64
  localparam int Q_DEPTH = 4;       // bundle queue depth between front and back
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int PROMPT_LEN = 5;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_V   = 8'h76;

  typedef enum logic [2:0] {
    PH_TOKEN, PH_CLASS, PH_QUOTE, PH_STRING, PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE, ESC_BSL, ESC_OCT1, ESC_OCT2
  } esc_t;

  typedef enum logic [3:0] {
    KIND_UNKNOWN, KIND_RESULT, KIND_EXEC, KIND_STATUS, KIND_NOTIFY,
    KIND_CONSOLE, KIND_TARGET, KIND_LOG, KIND_PROMPT
  } kind_t;

  typedef enum logic {
    RT_PAYLOAD, RT_END
  } rtype_t;

  typedef struct packed {
    phase_t               phase;
    esc_t                 esc;
    logic [8:0]           oct;
    logic [TOKEN_W-1:0]   token;
    kind_t                kind;
    logic [2:0]           pidx;
    logic                 pmis;
    logic                 nonempty;
  } line_st_t;

  typedef struct packed {
    rtype_t     rtype;
    logic [7:0] data;
    kind_t      kind;
  } entry_t;

  // all results caused by one input beat
  typedef struct packed {
    logic [1:0]       cnt;
    entry_t [2:0]     ent;
    logic [31:0]      token;
  } bundle_t;

  typedef struct packed {
    line_st_t st;
    logic     held;
    bundle_t  bd;
  } step_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam line_st_t LINE_RESET = '{
    phase: PH_TOKEN, esc: ESC_NONE, oct: '0, token: '0,
    kind: KIND_UNKNOWN, pidx: '0, pmis: 1'b0, nonempty: 1'b0
  };

  function automatic logic [7:0] prompt_char(logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h28;  // (
      3'd1:    c = 8'h67;
      3'd2:    c = 8'h64;
      3'd3:    c = 8'h62;
      3'd4:    c = 8'h29;  // )
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic step_res_t put(step_res_t r, rtype_t t, logic [7:0] d, kind_t k);
    if (r.bd.cnt != 2'd3) begin
      r.bd.ent[r.bd.cnt].rtype = t;
      r.bd.ent[r.bd.cnt].data  = d;
      r.bd.ent[r.bd.cnt].kind  = k;
      r.bd.cnt = r.bd.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic logic is_octal(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_SEVEN);
  endfunction

  function automatic step_res_t str_byte(step_res_t r, logic [7:0] b);
    logic       done;
    logic [8:0] o;
    done = 1'b0;
    o = '0;
    if (r.st.esc == ESC_OCT1 || r.st.esc == ESC_OCT2) begin
      if (is_octal(b)) begin
        o = {r.st.oct[5:0], b[2:0]};
        if (r.st.esc == ESC_OCT2) begin
          r = put(r, RT_PAYLOAD, o[7:0], r.st.kind);
          r.st.esc = ESC_NONE;
          r.st.oct = '0;
        end else begin
          r.st.oct = o;
          r.st.esc = ESC_OCT2;
        end
        done = 1'b1;
      end else begin
        // short octal run ends, then b is handled as plain string text
        r = put(r, RT_PAYLOAD, r.st.oct[7:0], r.st.kind);
        r.st.esc = ESC_NONE;
        r.st.oct = '0;
      end
    end
    if (!done && r.st.esc == ESC_BSL) begin
      r.st.esc = ESC_NONE;
      unique case (b)
        CH_LC_N: r = put(r, RT_PAYLOAD, CH_LF, r.st.kind);
        CH_LC_R: r = put(r, RT_PAYLOAD, CH_CR, r.st.kind);
        CH_LC_T: r = put(r, RT_PAYLOAD, CH_TAB, r.st.kind);
        CH_LC_B: r = put(r, RT_PAYLOAD, CH_BS, r.st.kind);
        CH_LC_F: r = put(r, RT_PAYLOAD, CH_FF, r.st.kind);
        CH_LC_V: r = put(r, RT_PAYLOAD, CH_VT, r.st.kind);
        default: begin
          if (is_octal(b)) begin
            r.st.oct = {6'd0, b[2:0]};
            r.st.esc = ESC_OCT1;
          end else begin
            r = put(r, RT_PAYLOAD, b, r.st.kind);
          end
        end
      endcase
      done = 1'b1;
    end
    if (!done) begin
      if (b == CH_QUOTE) r.st.phase = PH_SKIP;
      else if (b == CH_BSLASH) r.st.esc = ESC_BSL;
      else r = put(r, RT_PAYLOAD, b, r.st.kind);
    end
    return r;
  endfunction

  function automatic step_res_t line_byte(step_res_t r, logic [7:0] b);
    r.st.nonempty = 1'b1;
    if (!r.st.pmis) begin
      if (r.st.pidx < 3'(PROMPT_LEN) && b == prompt_char(r.st.pidx))
        r.st.pidx = r.st.pidx + 3'd1;
      else
        r.st.pmis = 1'b1;
    end
    unique case (r.st.phase)
      PH_TOKEN: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          r.st.token = (r.st.token << 3) + (r.st.token << 1) + TOKEN_W'(b[3:0]);
        end else begin
          unique case (b)
            CH_CARET: begin r.st.kind = KIND_RESULT;  r.st.phase = PH_CLASS; end
            CH_STAR:  begin r.st.kind = KIND_EXEC;    r.st.phase = PH_CLASS; end
            CH_PLUS:  begin r.st.kind = KIND_STATUS;  r.st.phase = PH_CLASS; end
            CH_EQUAL: begin r.st.kind = KIND_NOTIFY;  r.st.phase = PH_CLASS; end
            CH_TILDE: begin r.st.kind = KIND_CONSOLE; r.st.phase = PH_QUOTE; end
            CH_AT:    begin r.st.kind = KIND_TARGET;  r.st.phase = PH_QUOTE; end
            CH_AMP:   begin r.st.kind = KIND_LOG;     r.st.phase = PH_QUOTE; end
            default:  begin r.st.kind = KIND_UNKNOWN; r.st.phase = PH_SKIP;  end
          endcase
        end
      end
      PH_CLASS: begin
        if (b == CH_COMMA) r.st.phase = PH_SKIP;
        else r = put(r, RT_PAYLOAD, b, r.st.kind);
      end
      PH_QUOTE: r.st.phase = (b == CH_QUOTE) ? PH_STRING : PH_SKIP;
      PH_STRING: r = str_byte(r, b);
      default: ;
    endcase
    return r;
  endfunction

  function automatic step_res_t end_line(step_res_t r);
    kind_t k;
    if (r.st.phase == PH_STRING) begin
      if (r.st.esc == ESC_BSL) r = put(r, RT_PAYLOAD, CH_BSLASH, r.st.kind);
      else if (r.st.esc == ESC_OCT1 || r.st.esc == ESC_OCT2)
        r = put(r, RT_PAYLOAD, r.st.oct[7:0], r.st.kind);
    end
    if (r.st.nonempty) begin
      k = (!r.st.pmis && r.st.pidx == 3'(PROMPT_LEN)) ? KIND_PROMPT : r.st.kind;
      r = put(r, RT_END, 8'h00, k);
    end
    r.bd.token = 32'(r.st.token);
    r.st = LINE_RESET;
    return r;
  endfunction

  // one input beat against the running line state
  function automatic step_res_t step(line_st_t st, logic held, logic op, logic [7:0] b);
    step_res_t r;
    r.st = st;
    r.held = held;
    r.bd = '0;
    if (op || b == CH_LF) begin
      r.held = 1'b0;
      r = end_line(r);
    end else begin
      if (b == CH_CR) begin
        if (held) r = line_byte(r, CH_CR);
        r.held = 1'b1;
      end else begin
        if (held) r = line_byte(r, CH_CR);
        r = line_byte(r, b);
        r.held = 1'b0;
      end
      r.bd.token = 32'(r.st.token);
    end
    return r;
  endfunction

endpackage

// File: hdl/misp_front.sv
// Front end: accepts input beats, runs the line parser state and builds result bundles.
// Depends on misp_pkg; feeds misp_queue.
`timescale 1ns / 1ps

module misp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // data_byte
  input  logic                s_tuser,   // op
  input  misp_pkg::q_status_t q_stat,
  output logic                push,
  output misp_pkg::bundle_t   push_data
);
  import misp_pkg::*;

  line_st_t  st, st_next;
  logic      held, held_next;
  step_res_t res;
  logic      accept;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    res = step(st, held, s_tuser, s_tdata);
  end

  always_comb begin
    st_next   = st;
    held_next = held;
    if (accept) begin
      st_next   = res.st;
      held_next = res.held;
    end
  end

  always_comb begin
    push      = accept && (res.bd.cnt != 2'd0);
    push_data = res.bd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= LINE_RESET;
      held <= 1'b0;
    end else begin
      st   <= st_next;
      held <= held_next;
    end
  end

endmodule

// File: hdl/misp_queue.sv
// Short register queue of result bundles between front and back.
// Depends on misp_pkg.
`timescale 1ns / 1ps

module misp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  misp_pkg::bundle_t   push_data,
  input  logic                pop,
  output misp_pkg::bundle_t   head,
  output misp_pkg::q_status_t q_stat
);
  import misp_pkg::*;

  bundle_t         slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   count, count_next;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign q_stat.empty = (count == '0);

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 1'b1;
    else if (pop && !push) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count_next;
    end
  end

endmodule

// File: hdl/misp_back.sv
// Back end: walks the head bundle one result per beat into the output register.
// Depends on misp_pkg; drains misp_queue.
`timescale 1ns / 1ps

module misp_back (
  input  logic                clk,
  input  logic                rst,
  input  misp_pkg::bundle_t   head,
  input  misp_pkg::q_status_t q_stat,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata,   // payload_byte, record_kind, token_value, zero pad
  output logic                m_tuser,   // result_type
  output logic                m_tlast
);
  import misp_pkg::*;

  logic [1:0]  idx, idx_next;
  logic        load, is_last;
  entry_t      cur;
  entry_t      out_ent;
  logic [31:0] out_token;

  assign load    = !q_stat.empty && (!m_tvalid || m_tready);
  assign cur     = head.ent[idx];
  assign is_last = (idx == head.cnt - 2'd1);
  assign pop     = load && is_last;

  always_comb begin
    idx_next = idx;
    if (load) idx_next = is_last ? 2'd0 : idx + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ent   <= cur;
      out_token <= head.token;
      m_tlast   <= is_last;
    end
  end

  assign m_tdata = {4'd0, out_token, out_ent.kind, out_ent.data};
  assign m_tuser = out_ent.rtype;

endmodule

// File: hdl/mi_record_stream_parser_unit.sv
// Path: an accepted beat's results are written into a queue slot, then loaded into the output register.
// Throughput: one input beat per cycle while each beat yields at most one result and m_tready
//   stays high; the output register sends one result per cycle, so a beat with several results
//   holds it longer, with a four-bundle queue absorbing the difference until it fills.
// Reset (rst, synchronous): line state, held CR, queue pointers and output valid are cleared.
// Top level: misp_front -> misp_queue -> misp_back; depends on misp_pkg.
`timescale 1ns / 1ps

module mi_record_stream_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // payload_byte, record_kind, token_value, zero pad
  output logic        m_tuser,   // result_type
  output logic        m_tlast
);
  import misp_pkg::*;

  logic      push, pop;
  bundle_t   push_data, head;
  q_status_t q_stat;

  misp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  misp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  misp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for mi_record_stream_parser_unit: a short directed table, then random MI lines, with
// results checked against typed rows or an in-bench line parser. Depends on misp_pkg and the RTL.

module tb;
  import misp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_BEATS = 240;
  localparam int DIR_ROWS = 26;
  localparam logic [39:0] PROMPT_BYTES = 40'h28_67_64_62_29;  // first char in the top byte

  typedef struct {
    rtype_t      rtype;
    logic [7:0]  text;
    kind_t       kind;
    logic [31:0] token;
    logic        last;
  } rec_out_t;

  typedef struct packed {
    logic       op;
    logic [7:0] b;
  } beat_t;

  // typed = expectation written here; one = the row gives exactly one result, else none
  typedef struct packed {
    logic        op;
    logic [7:0]  b;
    logic        typed;
    logic        one;
    rtype_t      rtype;
    logic [7:0]  text;
    kind_t       kind;
    logic [31:0] token;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // line parser state
  phase_t             ln_phase;
  esc_t               ln_esc;
  logic [8:0]         ln_oct;
  logic [TOKEN_W-1:0] ln_token;
  kind_t              ln_kind;
  logic [2:0]         pr_idx;
  logic               pr_miss;
  logic               ln_seen;
  logic               held_cr;

  rec_out_t beat_recs[$];
  rec_out_t pending_results[$];
  beat_t    stim_q[$];
  rec_out_t head_rec;
  int       mismatch_count = 0;
  int       idle_cycles = 0;
  int       sink_hold = 0;
  logic     no_gaps = 1'b0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b1, 8'h00, 1'b1, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},  // flush, nothing pending
    '{1'b0, CH_LF, 1'b1, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},  // empty line
    '{1'b0, 8'h39, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, CH_CARET, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, 8'h78, 1'b1, 1'b1, RT_PAYLOAD, 8'h78, KIND_RESULT, 32'd9},
    '{1'b0, CH_COMMA, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, CH_CR, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, CH_LF, 1'b1, 1'b1, RT_END, 8'h00, KIND_RESULT, 32'd9},        // CR before LF dropped
    '{1'b0, CH_AMP, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, CH_QUOTE, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, CH_BSLASH, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, 8'h31, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, 8'h32, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, 8'h33, 1'b1, 1'b1, RT_PAYLOAD, 8'h53, KIND_LOG, 32'd0},      // three-digit octal
    '{1'b0, CH_BSLASH, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, CH_SEVEN, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, 8'h7A, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},  // short octal run
    '{1'b0, CH_BSLASH, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, 8'h71, 1'b1, 1'b1, RT_PAYLOAD, 8'h71, KIND_LOG, 32'd0},      // unknown escape
    '{1'b0, CH_BSLASH, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b1, 8'hA5, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},  // backslash at line end
    '{1'b0, 8'hFF, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, 8'h00, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, CH_CR, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},
    '{1'b0, 8'h41, 1'b0, 1'b0, RT_PAYLOAD, 8'h00, KIND_UNKNOWN, 32'd0},  // CR not before LF
    '{1'b1, 8'h00, 1'b1, 1'b1, RT_END, 8'h00, KIND_UNKNOWN, 32'd0}
  };

  mi_record_stream_parser_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 75) return $urandom_range(1, 2);
    if (p < 95) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  function automatic int sender_gap();
    if (no_gaps || $urandom_range(0, 9) < 7) return 0;
    return idle_len();
  endfunction

  task automatic emit(rtype_t t, logic [7:0] b);
    rec_out_t r;
    if (beat_recs.size() < 3) begin
      r.rtype = t;
      r.text  = b;
      r.kind  = ln_kind;
      r.token = 32'(ln_token);
      r.last  = 1'b0;
      beat_recs.insert(beat_recs.size(), r);
    end
  endtask

  task automatic clear_line();
    ln_phase = PH_TOKEN;
    ln_esc   = ESC_NONE;
    ln_oct   = '0;
    ln_token = '0;
    ln_kind  = KIND_UNKNOWN;
    pr_idx   = '0;
    pr_miss  = 1'b0;
    ln_seen  = 1'b0;
  endtask

  task automatic line_byte(logic [7:0] b);
    logic octal;
    logic handled;
    octal = (b >= CH_ZERO) && (b <= CH_SEVEN);
    handled = 1'b0;
    ln_seen = 1'b1;
    if (!pr_miss) begin
      if (pr_idx < 3'd5 && b == PROMPT_BYTES[39 - 8 * int'(pr_idx) -: 8]) pr_idx = pr_idx + 3'd1;
      else pr_miss = 1'b1;
    end
    case (ln_phase)
      PH_TOKEN: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          ln_token = ln_token * TOKEN_W'(10) + TOKEN_W'(b - CH_ZERO);
        end else begin
          case (b)
            CH_CARET: begin ln_kind = KIND_RESULT;  ln_phase = PH_CLASS; end
            CH_STAR:  begin ln_kind = KIND_EXEC;    ln_phase = PH_CLASS; end
            CH_PLUS:  begin ln_kind = KIND_STATUS;  ln_phase = PH_CLASS; end
            CH_EQUAL: begin ln_kind = KIND_NOTIFY;  ln_phase = PH_CLASS; end
            CH_TILDE: begin ln_kind = KIND_CONSOLE; ln_phase = PH_QUOTE; end
            CH_AT:    begin ln_kind = KIND_TARGET;  ln_phase = PH_QUOTE; end
            CH_AMP:   begin ln_kind = KIND_LOG;     ln_phase = PH_QUOTE; end
            default:  begin ln_kind = KIND_UNKNOWN; ln_phase = PH_SKIP;  end
          endcase
        end
      end
      PH_CLASS: begin
        if (b == CH_COMMA) ln_phase = PH_SKIP;
        else emit(RT_PAYLOAD, b);
      end
      PH_QUOTE: ln_phase = (b == CH_QUOTE) ? PH_STRING : PH_SKIP;
      PH_STRING: begin
        if (ln_esc == ESC_OCT1 || ln_esc == ESC_OCT2) begin
          if (octal) begin
            ln_oct = {ln_oct[5:0], b[2:0]};
            if (ln_esc == ESC_OCT2) begin
              emit(RT_PAYLOAD, ln_oct[7:0]);
              ln_esc = ESC_NONE;
              ln_oct = '0;
            end else begin
              ln_esc = ESC_OCT2;
            end
            handled = 1'b1;
          end else begin
            // run closed early; this byte then counts as ordinary text
            emit(RT_PAYLOAD, ln_oct[7:0]);
            ln_esc = ESC_NONE;
            ln_oct = '0;
          end
        end
        if (!handled && ln_esc == ESC_BSL) begin
          ln_esc = ESC_NONE;
          handled = 1'b1;
          case (b)
            CH_LC_N: emit(RT_PAYLOAD, CH_LF);
            CH_LC_R: emit(RT_PAYLOAD, CH_CR);
            CH_LC_T: emit(RT_PAYLOAD, CH_TAB);
            CH_LC_B: emit(RT_PAYLOAD, CH_BS);
            CH_LC_F: emit(RT_PAYLOAD, CH_FF);
            CH_LC_V: emit(RT_PAYLOAD, CH_VT);
            default: begin
              if (octal) begin
                ln_oct = {6'd0, b[2:0]};
                ln_esc = ESC_OCT1;
              end else begin
                emit(RT_PAYLOAD, b);
              end
            end
          endcase
        end
        if (!handled) begin
          if (b == CH_QUOTE) ln_phase = PH_SKIP;
          else if (b == CH_BSLASH) ln_esc = ESC_BSL;
          else emit(RT_PAYLOAD, b);
        end
      end
      default: ;
    endcase
  endtask

  // results of one accepted beat land in beat_recs
  task automatic parse_beat(logic op, logic [7:0] b);
    rec_out_t r;
    beat_recs.delete();
    if (op || b == CH_LF) begin
      held_cr = 1'b0;
      if (ln_phase == PH_STRING) begin
        if (ln_esc == ESC_BSL) emit(RT_PAYLOAD, CH_BSLASH);
        else if (ln_esc != ESC_NONE) emit(RT_PAYLOAD, ln_oct[7:0]);
      end
      if (ln_seen) begin
        if (!pr_miss && pr_idx == 3'd5) ln_kind = KIND_PROMPT;
        emit(RT_END, 8'h00);
      end
      clear_line();
    end else if (b == CH_CR) begin
      if (held_cr) line_byte(CH_CR);
      held_cr = 1'b1;
    end else begin
      if (held_cr) begin
        held_cr = 1'b0;
        line_byte(CH_CR);
      end
      line_byte(b);
    end
    if (beat_recs.size() > 0) begin
      r = beat_recs[beat_recs.size() - 1];
      r.last = 1'b1;
      beat_recs[beat_recs.size() - 1] = r;
    end
  endtask

  task automatic drive_beat(logic op, logic [7:0] b, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic add_beat(logic op, logic [7:0] b);
    beat_t t;
    t.op = op;
    t.b  = b;
    stim_q.insert(stim_q.size(), t);
  endtask

  task automatic report(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // result sink with random backpressure; checks each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result tdata=%h tuser=%b tlast=%b",
                   $time, m_tdata, m_tuser, m_tlast);
          mismatch_count++;
        end else begin
          head_rec = pending_results.pop_front();
          report("result_type", head_rec.rtype, m_tuser);
          report("payload_byte", head_rec.text, m_tdata[7:0]);
          report("record_kind", head_rec.kind, m_tdata[11:8]);
          report("token_value", head_rec.token, m_tdata[43:12]);
          report("tdata pad", 0, m_tdata[47:44]);
          report("last", head_rec.last, m_tlast);
        end
      end
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
      end else if ($urandom_range(0, 9) < 7) begin
        m_tready  <= 1'b1;
        sink_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      end else begin
        m_tready  <= 1'b0;
        sink_hold <= idle_len() - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sel;
    int p;
    int n;
    int m;
    logic [7:0] c;
    rec_out_t r;

    clear_line();
    held_cr = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      drive_beat(dir_tab[i].op, dir_tab[i].b, sender_gap());
      parse_beat(dir_tab[i].op, dir_tab[i].b);
      if (dir_tab[i].typed) begin
        if (dir_tab[i].one) begin
          r.rtype = dir_tab[i].rtype;
          r.text  = dir_tab[i].text;
          r.kind  = dir_tab[i].kind;
          r.token = dir_tab[i].token;
          r.last  = 1'b1;
          pending_results.insert(pending_results.size(), r);
        end
      end else begin
        foreach (beat_recs[j]) pending_results.insert(pending_results.size(), beat_recs[j]);
      end
    end

    // random MI lines: mostly well formed, some noise
    while (stim_q.size() < RAND_BEATS) begin
      sel = $urandom_range(0, 19);
      p = $urandom_range(0, 9);
      n = (p < 4) ? 0 : (p < 9) ? $urandom_range(1, 3) : $urandom_range(10, 14);
      if (sel >= 13 && sel <= 14 && $urandom_range(0, 3) != 0) n = 0;
      for (int i = 0; i < n; i++) add_beat(1'b0, CH_ZERO + 8'($urandom_range(0, 9)));
      if (sel <= 5) begin
        case ($urandom_range(0, 3))
          0: add_beat(1'b0, CH_CARET);
          1: add_beat(1'b0, CH_STAR);
          2: add_beat(1'b0, CH_PLUS);
          default: add_beat(1'b0, CH_EQUAL);
        endcase
        m = $urandom_range(0, 6);
        for (int i = 0; i < m; i++) add_beat(1'b0, 8'h61 + 8'($urandom_range(0, 25)));
        if ($urandom_range(0, 4) < 3) begin
          add_beat(1'b0, CH_COMMA);
          m = $urandom_range(0, 4);
          for (int i = 0; i < m; i++) add_beat(1'b0, 8'($urandom_range(32, 126)));
        end
      end else if (sel <= 12) begin
        case ($urandom_range(0, 2))
          0: add_beat(1'b0, CH_TILDE);
          1: add_beat(1'b0, CH_AT);
          default: add_beat(1'b0, CH_AMP);
        endcase
        if ($urandom_range(0, 7) != 0) add_beat(1'b0, CH_QUOTE);
        else add_beat(1'b0, 8'($urandom_range(32, 126)));
        m = $urandom_range(0, 6);
        for (int i = 0; i < m; i++) begin
          p = $urandom_range(0, 9);
          if (p <= 4) begin
            c = 8'($urandom_range(32, 126));
            if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h61;
            add_beat(1'b0, c);
          end else if (p == 5) begin
            add_beat(1'b0, ($urandom_range(0, 2) == 0) ? CH_CR : 8'($urandom_range(128, 255)));
          end else if (p <= 7) begin
            add_beat(1'b0, CH_BSLASH);
            case ($urandom_range(0, 6))
              0: add_beat(1'b0, CH_LC_N);
              1: add_beat(1'b0, CH_LC_R);
              2: add_beat(1'b0, CH_LC_T);
              3: add_beat(1'b0, CH_LC_B);
              4: add_beat(1'b0, CH_LC_F);
              5: add_beat(1'b0, CH_LC_V);
              default: add_beat(1'b0, 8'($urandom_range(32, 126)));
            endcase
          end else begin
            add_beat(1'b0, CH_BSLASH);
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) add_beat(1'b0, CH_ZERO + 8'($urandom_range(0, 7)));
          end
        end
        p = $urandom_range(0, 19);
        if (p < 14) begin
          add_beat(1'b0, CH_QUOTE);
          m = $urandom_range(0, 3);
          for (int i = 0; i < m; i++) add_beat(1'b0, 8'($urandom_range(32, 126)));
        end else if (p < 17) begin
          add_beat(1'b0, CH_BSLASH);
        end
      end else if (sel <= 14) begin
        p = $urandom_range(0, 9);
        m = (p == 7) ? $urandom_range(1, 4) : 5;
        for (int i = 0; i < m; i++) begin
          c = PROMPT_BYTES[39 - 8 * i -: 8];
          if (p == 9 && i == 2) c = c ^ 8'h01;
          add_beat(1'b0, c);
        end
        if (p == 8) add_beat(1'b0, 8'($urandom_range(32, 126)));
      end else if (sel == 15) begin
        m = $urandom_range(1, 14);
        for (int i = 0; i < m; i++) add_beat(1'b0, CH_ZERO + 8'($urandom_range(0, 9)));
      end else if (sel == 16) begin
        m = $urandom_range(1, 4);
        for (int i = 0; i < m; i++) add_beat(1'b0, 8'($urandom_range(33, 126)));
      end else begin
        m = $urandom_range(1, 6);
        for (int i = 0; i < m; i++) add_beat(1'b0, 8'($urandom_range(0, 255)));
      end
      p = $urandom_range(0, 19);
      if (p <= 11) begin
        add_beat(1'b0, CH_LF);
      end else if (p <= 14) begin
        add_beat(1'b0, CH_CR);
        add_beat(1'b0, CH_LF);
      end else if (p == 15) begin
        add_beat(1'b0, CH_CR);
        add_beat(1'b0, CH_CR);
        add_beat(1'b0, CH_LF);
      end else if (p <= 17) begin
        add_beat(1'b1, 8'($urandom_range(0, 255)));
      end else if (p == 18) begin
        add_beat(1'b0, CH_CR);
      end else begin
        add_beat(1'b0, CH_LF);
        add_beat(1'b1, 8'($urandom_range(0, 255)));
      end
    end

    foreach (stim_q[i]) begin
      if (i % 32 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i == stim_q.size() / 2) begin
        // hold the sender until every pending result has drained
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      drive_beat(stim_q[i].op, stim_q[i].b, sender_gap());
      parse_beat(stim_q[i].op, stim_q[i].b);
      foreach (beat_recs[j]) pending_results.insert(pending_results.size(), beat_recs[j]);
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/misp_pkg.sv
hdl/misp_front.sv
hdl/misp_queue.sv
hdl/misp_back.sv
hdl/mi_record_stream_parser_unit.sv
verif/tb.sv
